/* design/hwcf_pkg.sv */
// Shared types and constants of the hidden wall cell filter.
// Used by the front, queue, back and top level modules.
package hwcf_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 4096;

  localparam int unsigned GridWidthRst  = 64;
  localparam int unsigned GridHeightRst = 64;

  localparam int unsigned CfgDataW = 13;
  localparam int unsigned WidthRegW  = 11;
  localparam int unsigned HeightRegW = 13;

  // queue between front and back, power of two
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [1:0] CELL_WALL  = 2'd0;
  localparam logic [1:0] CELL_FLOOR = 2'd1;
  localparam logic [1:0] CELL_EMPTY = 2'd2;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  // what one accepted cell produces: an interior result, a border result, or both
  typedef struct packed {
    logic       int_v;
    logic [1:0] int_cell;
    logic       brd_v;
    logic [1:0] brd_cell;
    logic       done;
  } res_flags_t;

  localparam int unsigned FlagsW = $bits(res_flags_t);

endpackage

/* design/hwcf_front.sv */
// Front end: config registers, raster counters, line stores and 3x3 windows.
// Classifies each cell and pushes one queue entry per cell that gives results.
// Depends on hwcf_pkg.
module hwcf_front import hwcf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef,
  localparam int unsigned ColW = $clog2(MAX_WIDTH),
  localparam int unsigned RowW = $clog2(MAX_HEIGHT)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cell_valid_i,
  output logic                cell_stall_o,
  input  logic [1:0]          cell_code_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  cfg_reg_e            cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [QCntW-1:0]    q_count_i,
  output logic                push_o,
  output logic [ColW-1:0]     push_col_o,
  output logic [RowW-1:0]     push_row_o,
  output res_flags_t          push_flags_o
);

  localparam int unsigned WidthEff  = (GridWidthRst > MAX_WIDTH) ? MAX_WIDTH : GridWidthRst;
  localparam int unsigned HeightEff = (GridHeightRst > MAX_HEIGHT) ? MAX_HEIGHT : GridHeightRst;
  localparam logic [ColW-1:0] LastColRst = ColW'(WidthEff - 1);
  localparam logic [RowW-1:0] LastRowRst = RowW'(HeightEff - 1);

  logic [ColW-1:0] last_col_q, last_col_d;
  logic [RowW-1:0] last_row_q, last_row_d;
  logic [WidthRegW-1:0]  gw;
  logic [HeightRegW-1:0] gh;

  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic            accept;
  logic            at_last_col, at_last_row;

  logic [1:0] mid_mem [MAX_WIDTH];
  logic       up_mem  [MAX_WIDTH];
  logic [1:0] mid_rd_q;
  logic       up_rd_q;

  logic            s1_valid_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;
  logic [1:0]      s1_cell_q;
  logic            s1_int_v_q, s1_brd_v_q, s1_done_q;

  logic [2:0] win_top_q, win_top_d;
  logic [5:0] win_mid_q, win_mid_d;
  logic [2:0] win_bot_q, win_bot_d;
  logic [1:0] center, left_cell, right_cell;
  logic       floor_near;

  // config: store the clamped last column and last row
  assign cfg_ready_o = 1'b1;
  assign gw = cfg_wdata_i[WidthRegW-1:0];
  assign gh = cfg_wdata_i[HeightRegW-1:0];

  always_comb begin
    if (gw < WidthRegW'(3)) begin
      last_col_d = ColW'(2);
    end else if (32'(gw) > 32'(MAX_WIDTH)) begin
      last_col_d = ColW'(MAX_WIDTH - 1);
    end else begin
      last_col_d = ColW'(gw - WidthRegW'(1));
    end
    if (gh < HeightRegW'(3)) begin
      last_row_d = RowW'(2);
    end else if (32'(gh) > 32'(MAX_HEIGHT)) begin
      last_row_d = RowW'(MAX_HEIGHT - 1);
    end else begin
      last_row_d = RowW'(gh - HeightRegW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= LastColRst;
      last_row_q <= LastRowRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GRID_WIDTH:  last_col_q <= last_col_d;
        REG_GRID_HEIGHT: last_row_q <= last_row_d;
        default: ;
      endcase
    end
  end

  // hold input while the queue may not take what is in flight
  assign cell_stall_o = (32'(q_count_i) + 32'(s1_valid_q)) >= 32'(QDepth);
  assign accept       = cell_valid_i && !cell_stall_o;
  assign at_last_col  = col_q >= last_col_q;
  assign at_last_row  = row_q >= last_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (at_last_col) begin
        col_q <= '0;
        row_q <= at_last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // row just above: read old entry, write the arriving cell
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mid_rd_q      <= mid_mem[col_q];
      mid_mem[col_q] <= cell_code_i;
    end
  end

  // row two above: written from the stage-1 register, once the row-above entry is read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_rd_q <= up_mem[col_q];
    end
    if (s1_valid_q) begin
      up_mem[s1_col_q] <= (mid_rd_q == CELL_FLOOR);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_cell_q  <= cell_code_i;
      s1_int_v_q <= (row_q >= RowW'(2)) && (col_q >= ColW'(2)) &&
                    (row_q <= last_row_q) && (col_q <= last_col_q);
      s1_brd_v_q <= (row_q == '0) || (col_q == '0) || at_last_row || at_last_col;
      s1_done_q  <= at_last_row && at_last_col;
    end
  end

  // shift the windows by one column
  assign win_top_d = {win_top_q[1:0], up_rd_q};
  assign win_mid_d = {win_mid_q[3:0], mid_rd_q};
  assign win_bot_d = {win_bot_q[1:0], s1_cell_q == CELL_FLOOR};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_top_q <= '0;
      win_mid_q <= '0;
      win_bot_q <= '0;
    end else if (s1_valid_q) begin
      win_top_q <= win_top_d;
      win_mid_q <= win_mid_d;
      win_bot_q <= win_bot_d;
    end
  end

  assign left_cell  = win_mid_d[5:4];
  assign center     = win_mid_d[3:2];
  assign right_cell = win_mid_d[1:0];
  assign floor_near = (|win_top_d) || (|win_bot_d) ||
                      (left_cell == CELL_FLOOR) || (right_cell == CELL_FLOOR);

  always_comb begin
    push_flags_o.int_v    = s1_int_v_q;
    push_flags_o.int_cell = (center == CELL_WALL && !floor_near) ? CELL_EMPTY : center;
    push_flags_o.brd_v    = s1_brd_v_q;
    push_flags_o.brd_cell = (s1_cell_q == CELL_WALL) ? CELL_EMPTY : s1_cell_q;
    push_flags_o.done     = s1_done_q;
  end

  assign push_o     = s1_valid_q && (s1_int_v_q || s1_brd_v_q);
  assign push_col_o = s1_col_q;
  assign push_row_o = s1_row_q;

endmodule

/* design/hwcf_fifo.sv */
// Short queue of classified cells between front and back.
// Depends on hwcf_pkg for depth and count widths.
module hwcf_fifo import hwcf_pkg::*; #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [DATA_W-1:0] head_o,
  output logic [QCntW-1:0]  count_o
);

  logic [DATA_W-1:0] mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q;
  logic              do_pop;

  assign empty_o = (count_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      case ({push_i, do_pop})
        2'b10:   count_q <= count_q + QCntW'(1);
        2'b01:   count_q <= count_q - QCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* design/hwcf_back.sv */
// Back end: turns each queue entry into one or two result beats.
// Interior cell first, then the border cell; output register holds a stalled beat.
// Depends on hwcf_pkg.
module hwcf_back import hwcf_pkg::*; #(
  parameter int unsigned ColW = 10,
  parameter int unsigned RowW = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  logic [ColW-1:0] head_col_i,
  input  logic [RowW-1:0] head_row_i,
  input  res_flags_t      head_flags_i,
  output logic            pop_o,
  output logic            res_valid_o,
  input  logic            res_stall_i,
  output logic [ColW-1:0] cell_col_o,
  output logic [RowW-1:0] cell_row_o,
  output logic [1:0]      cell_out_o,
  output logic            last_o,
  output logic            grid_done_o
);

  logic            out_valid_q;
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [1:0]      cell_q;
  logic            last_q, done_q;
  logic            int_sent_q;
  logic            load_en, take, send_int;

  assign load_en  = !out_valid_q || !res_stall_i;
  assign take     = load_en && !empty_i;
  assign send_int = head_flags_i.int_v && !int_sent_q;
  // pop once the entry's final beat is loaded into the output register
  assign pop_o    = take && !(send_int && head_flags_i.brd_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      int_sent_q  <= 1'b0;
    end else if (load_en) begin
      out_valid_q <= !empty_i;
      if (take) begin
        int_sent_q <= send_int && head_flags_i.brd_v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (send_int) begin
        col_q  <= head_col_i - ColW'(1);
        row_q  <= head_row_i - RowW'(1);
        cell_q <= head_flags_i.int_cell;
        last_q <= !head_flags_i.brd_v;
        done_q <= 1'b0;
      end else begin
        col_q  <= head_col_i;
        row_q  <= head_row_i;
        cell_q <= head_flags_i.brd_cell;
        last_q <= 1'b1;
        done_q <= head_flags_i.done;
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign cell_col_o  = col_q;
  assign cell_row_o  = row_q;
  assign cell_out_o  = cell_q;
  assign last_o      = last_q;
  assign grid_done_o = done_q;

endmodule

/* design/hidden_wall_cell_filter_top.sv */
// Beats pass the stage-1 register, queue and output register: a border cell's beat
// after its accept, an interior cell's after the cell one right and one below is
// accepted. Throughput: one cell per cycle while the queue has room; right-column
// or bottom-row cells from column 2 and row 2 on give two beats, and the four-entry
// queue holds input off while output drains. Reset: counters, windows, config and
// queue clear; line stores stay undefined until written and get no clearing pass.
module hidden_wall_cell_filter_top import hwcf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef,
  localparam int unsigned ColW = $clog2(MAX_WIDTH),
  localparam int unsigned RowW = $clog2(MAX_HEIGHT)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cell_valid_i,
  output logic                cell_stall_o,
  input  logic [1:0]          cell_code_i,
  output logic                res_valid_o,
  input  logic                res_stall_i,
  output logic [ColW-1:0]     cell_col_o,
  output logic [RowW-1:0]     cell_row_o,
  output logic [1:0]          cell_out_o,
  output logic                last_o,
  output logic                grid_done_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  cfg_reg_e            cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned EntryW = ColW + RowW + FlagsW;

  logic              push;
  logic [ColW-1:0]   push_col;
  logic [RowW-1:0]   push_row;
  res_flags_t        push_flags;
  logic              pop, q_empty;
  logic [EntryW-1:0] q_head;
  logic [QCntW-1:0]  q_count;
  logic [ColW-1:0]   head_col;
  logic [RowW-1:0]   head_row;
  res_flags_t        head_flags;

  hwcf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_valid_i (cell_valid_i),
    .cell_stall_o (cell_stall_o),
    .cell_code_i  (cell_code_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_count_i    (q_count),
    .push_o       (push),
    .push_col_o   (push_col),
    .push_row_o   (push_row),
    .push_flags_o (push_flags)
  );

  hwcf_fifo #(
    .DATA_W (EntryW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_col, push_row, push_flags}),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (q_head),
    .count_o     (q_count)
  );

  assign head_col   = q_head[EntryW-1 -: ColW];
  assign head_row   = q_head[FlagsW+RowW-1 -: RowW];
  assign head_flags = res_flags_t'(q_head[FlagsW-1:0]);

  hwcf_back #(
    .ColW (ColW),
    .RowW (RowW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_col_i   (head_col),
    .head_row_i   (head_row),
    .head_flags_i (head_flags),
    .pop_o        (pop),
    .res_valid_o  (res_valid_o),
    .res_stall_i  (res_stall_i),
    .cell_col_o   (cell_col_o),
    .cell_row_o   (cell_row_o),
    .cell_out_o   (cell_out_o),
    .last_o       (last_o),
    .grid_done_o  (grid_done_o)
  );

endmodule

/* sim/hwcf_checker.sv */
// Watches the cell, result and register channels of the hidden wall cell filter,
// predicts every result beat and compares it with the block's beats.
// Depends on hwcf_pkg for cell codes, register indexes and register widths.
module hwcf_checker import hwcf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef,
  localparam int unsigned ColW = $clog2(MAX_WIDTH),
  localparam int unsigned RowW = $clog2(MAX_HEIGHT)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cell_valid_i,
  input  logic                cell_stall_i,
  input  logic [1:0]          cell_code_i,
  input  logic                res_valid_i,
  input  logic                res_stall_i,
  input  logic [ColW-1:0]     cell_col_i,
  input  logic [RowW-1:0]     cell_row_i,
  input  logic [1:0]          cell_out_i,
  input  logic                last_i,
  input  logic                grid_done_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  cfg_reg_e            cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  outstanding_o,
  output int                  miss_count_o
);

  localparam int MaxReports = 100;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic [1:0]      out_code;
    logic            last;
    logic            done;
  } cell_beat_t;

  cell_beat_t pending_cells [$];

  logic                  upper_floor [MAX_WIDTH];
  logic [1:0]            mid_cells   [MAX_WIDTH];
  logic [2:0]            win_top;
  logic [5:0]            win_mid;
  logic [2:0]            win_bot;
  int unsigned           col_cnt;
  int unsigned           row_cnt;
  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  int                    misses;

  initial begin
    misses = 0;
  end

  function automatic int unsigned span(input int unsigned v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_miss(input string what);
    misses++;
    if (misses <= MaxReports) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Run one accepted cell through the 3x3 window and queue the beats it causes.
  task automatic filter_cell(input logic [1:0] code);
    int unsigned w, h, c, r;
    logic        up, last_c, last_r, near, has_inner, has_rim;
    logic [1:0]  mid, centre;
    cell_beat_t  inner, rim;
    w      = span(width_q, MAX_WIDTH);
    h      = span(height_q, MAX_HEIGHT);
    c      = col_cnt;
    r      = row_cnt;
    last_c = (c >= w - 1);
    last_r = (r >= h - 1);
    up     = upper_floor[c];
    mid    = mid_cells[c];
    upper_floor[c] = (mid == CELL_FLOOR);
    mid_cells[c]   = code;
    win_top = {win_top[1:0], up};
    win_mid = {win_mid[3:0], mid};
    win_bot = {win_bot[1:0], code == CELL_FLOOR};

    has_inner = (r >= 2) && (c >= 2) && (r <= h - 1) && (c <= w - 1);
    has_rim   = (r == 0) || (c == 0) || last_r || last_c;

    centre = win_mid[3:2];
    near   = (win_top != 3'b000) || (win_bot != 3'b000) ||
             (win_mid[5:4] == CELL_FLOOR) || (win_mid[1:0] == CELL_FLOOR);
    inner.col      = ColW'(c - 1);
    inner.row      = RowW'(r - 1);
    inner.out_code = (centre == CELL_WALL && !near) ? CELL_EMPTY : centre;
    inner.last     = !has_rim;
    inner.done     = 1'b0;

    rim.col      = ColW'(c);
    rim.row      = RowW'(r);
    rim.out_code = (code == CELL_WALL) ? CELL_EMPTY : code;
    rim.last     = 1'b1;
    rim.done     = last_r && last_c;

    if (has_inner) pending_cells.push_back(inner);
    if (has_rim) pending_cells.push_back(rim);

    if (last_c) begin
      col_cnt = 0;
      row_cnt = last_r ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  always @(posedge clk_i) begin
    cell_beat_t want;
    if (!rst_ni) begin
      pending_cells.delete();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_floor[i] = 1'b0;
        mid_cells[i]   = CELL_WALL;
      end
      win_top  = '0;
      win_mid  = '0;
      win_bot  = '0;
      col_cnt  = 0;
      row_cnt  = 0;
      width_q  = WidthRegW'(GridWidthRst);
      height_q = HeightRegW'(GridHeightRst);
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_GRID_WIDTH) width_q = cfg_wdata_i[WidthRegW-1:0];
        else height_q = cfg_wdata_i[HeightRegW-1:0];
      end
      if (cell_valid_i && !cell_stall_i) filter_cell(cell_code_i);
      if (res_valid_i && !res_stall_i) begin
        if (pending_cells.size() == 0) begin
          report_miss($sformatf("unexpected beat col %0d row %0d cell %0d",
                                cell_col_i, cell_row_i, cell_out_i));
        end else begin
          want = pending_cells.pop_front();
          if (cell_col_i !== want.col)
            report_miss($sformatf("cell_col got %0d want %0d (row %0d)",
                                  cell_col_i, want.col, want.row));
          if (cell_row_i !== want.row)
            report_miss($sformatf("cell_row got %0d want %0d (col %0d)",
                                  cell_row_i, want.row, want.col));
          if (cell_out_i !== want.out_code)
            report_miss($sformatf("cell_out got %0d want %0d at col %0d row %0d",
                                  cell_out_i, want.out_code, want.col, want.row));
          if (last_i !== want.last)
            report_miss($sformatf("last got %0b want %0b at col %0d row %0d",
                                  last_i, want.last, want.col, want.row));
          if (grid_done_i !== want.done)
            report_miss($sformatf("grid_done got %0b want %0b at col %0d row %0d",
                                  grid_done_i, want.done, want.col, want.row));
        end
      end
    end
    outstanding_o <= pending_cells.size();
    miss_count_o  <= misses;
  end

endmodule

/* sim/tb.sv */
// Top of the hidden wall cell filter testbench: clock, reset, cell stream,
// register writes and the verdict. Depends on hwcf_pkg, the filter top and hwcf_checker.
module tb import hwcf_pkg::*;;

  localparam int unsigned ColW         = $clog2(MaxWidthDef);
  localparam int unsigned RowW         = $clog2(MaxHeightDef);
  localparam logic [1:0]  CellStray    = 2'd3;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomCells  = 400;

  // three 3x3 grids: a wall beside a floor, a wall with no floor but stray codes
  // around it, and a stray code walled in
  localparam logic [53:0] DemoCells = {
    CELL_WALL,  CELL_FLOOR, CELL_EMPTY,
    CellStray,  CELL_WALL,  CELL_EMPTY,
    CELL_EMPTY, CELL_EMPTY, CELL_WALL,
    CELL_EMPTY, CellStray,  CELL_EMPTY,
    CELL_WALL,  CELL_WALL,  CellStray,
    CELL_WALL,  CELL_EMPTY, CELL_WALL,
    CELL_WALL,  CELL_WALL,  CELL_WALL,
    CELL_WALL,  CellStray,  CELL_WALL,
    CELL_WALL,  CELL_WALL,  CELL_WALL
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cell_valid_i;
  logic                cell_stall_o;
  logic [1:0]          cell_code_i;
  logic                res_valid_o;
  logic                res_stall_i;
  logic [ColW-1:0]     cell_col_o;
  logic [RowW-1:0]     cell_row_o;
  logic [1:0]          cell_out_o;
  logic                last_o;
  logic                grid_done_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  cfg_reg_e            cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  int          outstanding;
  int          miss_count;
  logic        quiet;
  int unsigned pos_col;
  int unsigned pos_row;
  int unsigned cells_sent;
  int unsigned width_set;
  int unsigned height_set;

  hidden_wall_cell_filter_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_valid_i (cell_valid_i),
    .cell_stall_o (cell_stall_o),
    .cell_code_i  (cell_code_i),
    .res_valid_o  (res_valid_o),
    .res_stall_i  (res_stall_i),
    .cell_col_o   (cell_col_o),
    .cell_row_o   (cell_row_o),
    .cell_out_o   (cell_out_o),
    .last_o       (last_o),
    .grid_done_o  (grid_done_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  hwcf_checker #(
    .MAX_WIDTH  (MaxWidthDef),
    .MAX_HEIGHT (MaxHeightDef)
  ) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cell_valid_i  (cell_valid_i),
    .cell_stall_i  (cell_stall_o),
    .cell_code_i   (cell_code_i),
    .res_valid_i   (res_valid_o),
    .res_stall_i   (res_stall_i),
    .cell_col_i    (cell_col_o),
    .cell_row_i    (cell_row_o),
    .cell_out_i    (cell_out_o),
    .last_i        (last_o),
    .grid_done_i   (grid_done_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .outstanding_o (outstanding),
    .miss_count_o  (miss_count)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    res_stall_i <= !quiet && ($urandom_range(99) < 30);
  end

  initial begin
    #(20 * 200000);
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned eff_size(input int unsigned v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [1:0] pick_cell(input bit noisy);
    int unsigned p;
    if (noisy) return 2'($urandom_range(3));
    p = $urandom_range(99);
    if (p < 45) return CELL_WALL;
    if (p < 65) return CELL_FLOOR;
    if (p < 92) return CELL_EMPTY;
    return CellStray;
  endfunction

  // Offer one cell beat, hold it until accepted, and track the grid position.
  task automatic send_cell(input logic [1:0] code);
    int unsigned w, h;
    while (!quiet && $urandom_range(99) < 30) begin
      cell_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cell_valid_i <= 1'b1;
    cell_code_i  <= code;
    @(posedge clk_i);
    while (cell_stall_o) @(posedge clk_i);
    w = eff_size(width_set, MaxWidthDef);
    h = eff_size(height_set, MaxHeightDef);
    if (pos_col >= w - 1) begin
      pos_col = 0;
      pos_row = (pos_row >= h - 1) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
    cells_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending and wait for every outstanding beat, then let the pipe settle.
  task automatic drain();
    cell_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_GRID_WIDTH) width_set = value[WidthRegW-1:0];
    else height_set = value[HeightRegW-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic finish_frame(input bit noisy);
    do send_cell(pick_cell(noisy)); while (pos_col != 0 || pos_row != 0);
  endtask

  initial begin
    int unsigned start, phase, w, h, k;
    bit          noisy;
    rst_ni       = 1'b0;
    cell_valid_i = 1'b0;
    cell_code_i  = CELL_WALL;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_GRID_WIDTH;
    cfg_wdata_i  = '0;
    quiet        = 1'b0;
    pos_col      = 0;
    pos_row      = 0;
    cells_sent   = 0;
    width_set    = GridWidthRst;
    height_set   = GridHeightRst;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset width: one full row and a bit, then shrink below range mid grid.
    repeat (66) send_cell(pick_cell(1'b1));
    drain();
    write_reg(REG_GRID_WIDTH, CfgDataW'(0));
    write_reg(REG_GRID_HEIGHT, CfgDataW'(0));
    finish_frame(1'b0);

    drain();
    write_reg(REG_GRID_WIDTH, CfgDataW'(3));
    write_reg(REG_GRID_HEIGHT, CfgDataW'(3));
    for (int i = 0; i < 27; i++) send_cell(DemoCells[2 * (26 - i) +: 2]);

    // Widest grid, clamped from above; one full row reaches the clamped last
    // column. Cut it short by shrinking; the narrow widths used later only
    // read line store entries written by now.
    drain();
    write_reg(REG_GRID_WIDTH, CfgDataW'(2047));
    write_reg(REG_GRID_HEIGHT, CfgDataW'(8191));
    repeat (MaxWidthDef + 4) send_cell(pick_cell(1'b0));
    drain();
    write_reg(REG_GRID_WIDTH, CfgDataW'(13'h1802));
    write_reg(REG_GRID_HEIGHT, CfgDataW'(1));
    finish_frame(1'b0);

    start = cells_sent;
    phase = 0;
    while (cells_sent - start < RandomCells) begin
      noisy = ($urandom_range(9) < 3);
      drain();
      if (phase == 1) begin
        quiet <= 1'b1;
        write_reg(REG_GRID_WIDTH, CfgDataW'(12));
        write_reg(REG_GRID_HEIGHT, CfgDataW'(10));
        finish_frame(1'b0);
        quiet <= 1'b0;
      end else if ($urandom_range(9) < 3) begin
        // stop mid grid, resize while idle, then run out the rest
        w = eff_size(width_set, MaxWidthDef);
        h = eff_size(height_set, MaxHeightDef);
        k = $urandom_range(1, w * h - 1);
        repeat (k) send_cell(pick_cell(noisy));
        drain();
        if ($urandom_range(1)) begin
          write_reg(REG_GRID_WIDTH, CfgDataW'($urandom_range(0, 12)));
          if ($urandom_range(1)) write_reg(REG_GRID_HEIGHT, CfgDataW'($urandom_range(0, 12)));
        end else begin
          write_reg(REG_GRID_HEIGHT, CfgDataW'($urandom_range(0, 12)));
        end
        finish_frame(noisy);
      end else begin
        if ($urandom_range(9) < 7) begin
          case ($urandom_range(9))
            0:       write_reg(REG_GRID_WIDTH, CfgDataW'($urandom_range(0, 2)));
            1:       write_reg(REG_GRID_WIDTH, CfgDataW'(13'h1800 | $urandom_range(3, 9)));
            default: write_reg(REG_GRID_WIDTH, CfgDataW'($urandom_range(3, 12)));
          endcase
        end
        if ($urandom_range(9) < 7) begin
          if ($urandom_range(9) == 0) write_reg(REG_GRID_HEIGHT, CfgDataW'($urandom_range(0, 2)));
          else write_reg(REG_GRID_HEIGHT, CfgDataW'($urandom_range(3, 10)));
        end
        repeat ($urandom_range(1, 2)) finish_frame(noisy);
      end
      phase++;
    end

    drain();
    if (miss_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
